// ===== design/pco_pkg.sv =====
// ----------------------------------------------------------------------------
// pco_pkg
// Shared types, register codes and constants for the pixel point operator.
// ----------------------------------------------------------------------------
package pco_pkg;

   localparam int FIELD_W = 16;

   typedef logic [FIELD_W-1:0] field_type;

   typedef struct packed {
      field_type blue;
      field_type green;
      field_type red;
   } rgb_type;

   // mode codes
   localparam logic [2:0] MODE_BITMAP = 3'd0;
   localparam logic [2:0] MODE_GRAY   = 3'd1;
   localparam logic [2:0] MODE_KEEP   = 3'd2;
   localparam logic [2:0] MODE_DROP   = 3'd3;
   localparam logic [2:0] MODE_SEPIA  = 3'd4;

   // register indexes
   localparam logic [1:0] REG_MODE     = 2'd0;
   localparam logic [1:0] REG_CHANNEL  = 2'd1;
   localparam logic [1:0] REG_MAX      = 2'd2;
   localparam logic [1:0] REG_GRAY_MAX = 2'd3;

   // sepia weights in thousandths, row = output channel, column = input channel
   localparam logic [9:0] SEPIA_W [3][3] = '{
      '{10'd393, 10'd769, 10'd189},
      '{10'd349, 10'd686, 10'd168},
      '{10'd272, 10'd534, 10'd131}
   };

   // x / 1000 = (x >> 3) / 125, the latter by reciprocal multiply and one fixup
   localparam int          RECIP_SHIFT = 31;
   localparam logic [24:0] RECIP_125   = 25'd17179869;
   localparam int          SEPIA_LAT   = 5;

endpackage

// ===== design/pco_sepia.sv =====
// ----------------------------------------------------------------------------
// pco_sepia
// Five-stage sepia matrix: weight products, sums, reciprocal divide by 1000,
// fixup and clamp to the maximum sample value.
// ----------------------------------------------------------------------------
module pco_sepia #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [SAMPLE_BITS-1:0] red,
   input  logic [SAMPLE_BITS-1:0] green,
   input  logic [SAMPLE_BITS-1:0] blue,
   input  pco_pkg::field_type     max_value,
   output pco_pkg::rgb_type       sepia
);

   localparam int PW = SAMPLE_BITS + 10;
   localparam int VW = SAMPLE_BITS + 11;
   localparam int XW = SAMPLE_BITS + 8;
   localparam int MW = XW + 25;
   localparam int QW = SAMPLE_BITS + 1;
   localparam int CW = 18;

   logic [SAMPLE_BITS-1:0] px [3];
   logic [PW-1:0] prod_ff [3][3];
   logic [VW-1:0] sum_ff  [3];
   logic [MW-1:0] mul_ff  [3];
   logic [XW-1:0] x_ff    [3];
   logic [XW-1:0] x2_ff   [3];
   logic [QW-1:0] q0_ff   [3];
   pco_pkg::field_type res_ff [3];
   logic [XW-1:0] rem     [3];
   logic [QW-1:0] quo     [3];

   assign px[0] = red;
   assign px[1] = green;
   assign px[2] = blue;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rem[c] = x2_ff[c] - (XW'(q0_ff[c]) * XW'(7'd125));
         quo[c] = q0_ff[c] + QW'(rem[c] >= XW'(125));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int c = 0; c < 3; c++) begin
            for (int j = 0; j < 3; j++) begin
               prod_ff[c][j] <= PW'(px[j]) * PW'(pco_pkg::SEPIA_W[c][j]);
            end
            sum_ff[c] <= VW'(prod_ff[c][0]) + VW'(prod_ff[c][1]) + VW'(prod_ff[c][2]);
            x_ff[c]   <= sum_ff[c][VW-1:3];
            mul_ff[c] <= MW'(sum_ff[c][VW-1:3]) * MW'(pco_pkg::RECIP_125);
            x2_ff[c]  <= x_ff[c];
            q0_ff[c]  <= mul_ff[c][pco_pkg::RECIP_SHIFT +: QW];
            if (CW'(quo[c]) > CW'(max_value)) begin
               res_ff[c] <= max_value;
            end else begin
               res_ff[c] <= pco_pkg::FIELD_W'(quo[c]);
            end
         end
      end
   end

   assign sepia.red   = res_ff[0];
   assign sepia.green = res_ff[1];
   assign sepia.blue  = res_ff[2];

endmodule

// ===== design/pco_div.sv =====
// ----------------------------------------------------------------------------
// pco_div
// Pipelined gray level: sum * gray_max / (3 * max_value), one quotient bit
// per stage by restoring division, saturated to the sample range.
// ----------------------------------------------------------------------------
module pco_div #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [SAMPLE_BITS+1:0] sum,
   input  pco_pkg::field_type     gray_max,
   input  pco_pkg::field_type     max_value,
   output logic [SAMPLE_BITS-1:0] gray
);

   localparam int QW = SAMPLE_BITS;
   localparam int DW = 18;
   localparam int NW = SAMPLE_BITS + 18;

   logic [NW-1:0] num_ff;
   logic [DW-1:0] den_ff;
   logic [NW-1:0] rem_ff   [QW+1];
   logic [DW-1:0] den_s_ff [QW+1];
   logic [QW-1:0] q_ff     [QW+1];
   logic          sat_ff   [QW+1];
   logic [NW-1:0] shd      [QW];
   logic          ge       [QW];

   always_comb begin
      for (int k = 0; k < QW; k++) begin
         shd[k] = NW'(den_s_ff[k]) << (QW - 1 - k);
         ge[k]  = rem_ff[k] >= shd[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= NW'(sum) * NW'(gray_max);
         den_ff <= {2'b00, max_value} + {1'b0, max_value, 1'b0};
         rem_ff[0]   <= num_ff;
         den_s_ff[0] <= den_ff;
         q_ff[0]     <= '0;
         // quotient would not fit the sample range
         sat_ff[0]   <= num_ff >= {den_ff, {QW{1'b0}}};
         for (int k = 0; k < QW; k++) begin
            rem_ff[k+1]   <= ge[k] ? rem_ff[k] - shd[k] : rem_ff[k];
            q_ff[k+1]     <= q_ff[k] | (QW'(ge[k]) << (QW - 1 - k));
            den_s_ff[k+1] <= den_s_ff[k];
            sat_ff[k+1]   <= sat_ff[k];
         end
      end
   end

   assign gray = sat_ff[QW] ? {QW{1'b1}} : q_ff[QW];

endmodule

// ===== design/pixel_color_point_ops.sv =====
// Each beat passes the entry register, the delay line and the result register.
// Throughput: one pixel per clock while the result is not stalled; the gray divider retires
// one quotient bit per pipeline stage, which sets the depth.
// A stalled result stalls the whole pipeline in place.
// Reset clears all valid bits and loads mode 0, channel 0, max 255, gray max 255.
// ----------------------------------------------------------------------------
// pixel_color_point_ops
// Per-pixel bitmap, gray, keep/drop channel and sepia operator, streaming; other mode codes pass through.
// ----------------------------------------------------------------------------
module pixel_color_point_ops #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // red_in, green_in, blue_in
   input  logic        req_tlast,   // frame_end_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // red_out, green_out, blue_out, mono_out
   output logic        rsp_tlast,   // frame_end_out
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int SW  = SAMPLE_BITS;
   localparam int DL  = SAMPLE_BITS + 2;
   localparam int PAD = DL - pco_pkg::SEPIA_LAT;

   logic [2:0]         mode_ff;
   logic [1:0]         channel_ff;
   pco_pkg::field_type max_ff;
   pco_pkg::field_type gray_max_ff;

   logic          en;
   logic          s1_vld_ff;
   logic          s1_last_ff;
   logic [SW-1:0] s1_px_ff [3];
   logic [SW+1:0] s1_sum;
   logic          s1_dark;

   logic          vld_ff  [DL];
   logic          last_ff [DL];
   logic          dark_ff [DL];
   logic [SW-1:0] pxd_ff  [DL][3];
   pco_pkg::rgb_type sep_pad_ff [PAD];
   pco_pkg::rgb_type sepia;
   logic [SW-1:0]    gray;

   logic          rsp_tvalid_ff;
   logic          rsp_tlast_ff;
   logic [63:0]   rsp_tdata_ff;
   pco_pkg::field_type out_px [3];
   pco_pkg::field_type res    [3];
   pco_pkg::field_type mono;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= pco_pkg::MODE_BITMAP;
         channel_ff  <= 2'd0;
         max_ff      <= 16'd255;
         gray_max_ff <= 16'd255;
      end else if (csr_valid) begin
         unique case (csr_index)
            pco_pkg::REG_MODE:     mode_ff     <= csr_data[2:0];
            pco_pkg::REG_CHANNEL:  channel_ff  <= csr_data[1:0];
            pco_pkg::REG_MAX:      max_ff      <= csr_data;
            pco_pkg::REG_GRAY_MAX: gray_max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // whole pipe advances unless the result register is held
   assign en         = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         for (int i = 0; i < DL; i++) begin
            vld_ff[i] <= 1'b0;
         end
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req_tvalid;
         vld_ff[0] <= s1_vld_ff;
         for (int i = 1; i < DL; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         rsp_tvalid_ff <= vld_ff[DL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_last_ff  <= req_tlast;
         s1_px_ff[0] <= req_tdata[SW-1:0];
         s1_px_ff[1] <= req_tdata[16 +: SW];
         s1_px_ff[2] <= req_tdata[32 +: SW];
      end
   end

   assign s1_sum  = (SW+2)'(s1_px_ff[0]) + (SW+2)'(s1_px_ff[1]) + (SW+2)'(s1_px_ff[2]);
   // floor(sum/3) < t  is the same as  sum < 3t
   assign s1_dark = 18'(s1_sum) < ({3'b000, max_ff[15:1]} + {2'b00, max_ff[15:1], 1'b0});

   always_ff @(posedge clock) begin
      if (en) begin
         last_ff[0] <= s1_last_ff;
         dark_ff[0] <= s1_dark;
         pxd_ff[0]  <= s1_px_ff;
         for (int i = 1; i < DL; i++) begin
            last_ff[i] <= last_ff[i-1];
            dark_ff[i] <= dark_ff[i-1];
            pxd_ff[i]  <= pxd_ff[i-1];
         end
         sep_pad_ff[0] <= sepia;
         for (int i = 1; i < PAD; i++) begin
            sep_pad_ff[i] <= sep_pad_ff[i-1];
         end
      end
   end

   pco_sepia #(.SAMPLE_BITS(SAMPLE_BITS)) u_sepia (
      .clock     (clock),
      .en        (en),
      .red       (s1_px_ff[0]),
      .green     (s1_px_ff[1]),
      .blue      (s1_px_ff[2]),
      .max_value (max_ff),
      .sepia     (sepia)
   );

   pco_div #(.SAMPLE_BITS(SAMPLE_BITS)) u_div (
      .clock     (clock),
      .en        (en),
      .sum       (s1_sum),
      .gray_max  (gray_max_ff),
      .max_value (max_ff),
      .gray      (gray)
   );

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         out_px[i] = pco_pkg::FIELD_W'(pxd_ff[DL-1][i]);
         res[i]    = '0;
      end
      mono = '0;
      unique case (mode_ff)
         pco_pkg::MODE_BITMAP: mono = pco_pkg::FIELD_W'(dark_ff[DL-1]);
         pco_pkg::MODE_GRAY: begin
            mono = (max_ff == '0) ? '0 : pco_pkg::FIELD_W'(gray);
         end
         pco_pkg::MODE_KEEP: begin
            for (int i = 0; i < 3; i++) begin
               res[i] = (channel_ff == 2'(i)) ? out_px[i] : '0;
            end
         end
         pco_pkg::MODE_DROP: begin
            for (int i = 0; i < 3; i++) begin
               res[i] = (channel_ff == 2'(i)) ? '0 : out_px[i];
            end
         end
         pco_pkg::MODE_SEPIA: begin
            res[0] = sep_pad_ff[PAD-1].red;
            res[1] = sep_pad_ff[PAD-1].green;
            res[2] = sep_pad_ff[PAD-1].blue;
         end
         default: begin
            res = out_px;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= {mono, res[2], res[1], res[0]};
         rsp_tlast_ff <= last_ff[DL-1];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

`ifndef SYNTHESIS
   a_rsp_from_pipe: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(vld_ff[DL-1]))
      else $error("result beat without a valid pipeline item");

   a_stall_holds_entry: assert property (@(posedge clock) disable iff (reset)
      !req_tready |=> $stable(s1_vld_ff))
      else $error("entry stage moved during a stall");

   a_entry_advances: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && en) |=> vld_ff[0])
      else $error("item lost between entry and pipeline");
`endif

endmodule
